// File: design/nsr_pkg.sv
package nsr_pkg;

  // Fixed field widths
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned REF_W   = 24;
  localparam int unsigned TOL_W   = 16;
  localparam int unsigned STEP_W  = 6;

  // Tolerance after reset, about 0.01 in Q16.16
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture a new transaction, seed the estimate
    logic div_start;  // launch one division value / estimate
    logic update;     // apply the Newton step, count it
    logic finish;     // latch the step-bound flag
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic within_tol;
    logic at_limit;
  } ctrl_status_t;

endpackage

// File: design/newton_square_root.sv
// Channel   Direction  Signals                                  Handshake
// command   in         value_i, reference_root_i                start, busy
// result    out        approx_root_o, step_count_o,             result_valid_o
//                      limit_reached_o
// config    in         cfg_tolerance_i                          cfg_valid_i, cfg_ready_o
//
// A transaction seeds the estimate, then runs N Newton steps, each a division,
// an update and a test (Q16.16 by default); the bit-serial divider sets the step time.
// rst_ni clears the controller and loads the tolerance with 655 (about 0.01).
// busy stays high from acceptance until the result strobe; result_valid_o is
// high for one cycle and the receiver cannot stall it.
module newton_square_root #(
  parameter int unsigned MAX_STEPS     = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [nsr_pkg::VALUE_W-1:0] value_i,
  input  logic [nsr_pkg::REF_W-1:0]   reference_root_i,
  output logic                        result_valid_o,
  output logic [nsr_pkg::VALUE_W-1:0] approx_root_o,
  output logic [nsr_pkg::STEP_W-1:0]  step_count_o,
  output logic                        limit_reached_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [nsr_pkg::TOL_W-1:0]   cfg_tolerance_i
);
  import nsr_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Accept register writes at any time
  assign cfg_ready_o = 1'b1;

  nsr_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd),
    .status_i       (status)
  );

  nsr_datapath #(
    .MAX_STEPS     (MAX_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .value_i          (value_i),
    .reference_root_i (reference_root_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_tolerance_i  (cfg_tolerance_i),
    .approx_root_o    (approx_root_o),
    .step_count_o     (step_count_o),
    .limit_reached_o  (limit_reached_o)
  );

endmodule

// File: design/nsr_div.sv
module nsr_div #(
  parameter int unsigned DIVIDEND_W = 48,
  parameter int unsigned DIVISOR_W  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int unsigned CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  // Restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = (trial >= {1'b0, div_q});

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (run_q) begin
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Advance the shift registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// File: design/nsr_datapath.sv
module nsr_datapath #(
  parameter int unsigned MAX_STEPS     = 32,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nsr_pkg::ctrl_cmd_t            cmd_i,
  output nsr_pkg::ctrl_status_t         status_o,
  input  logic [nsr_pkg::VALUE_W-1:0]   value_i,
  input  logic [nsr_pkg::REF_W-1:0]     reference_root_i,
  input  logic                          cfg_we_i,
  input  logic [nsr_pkg::TOL_W-1:0]     cfg_tolerance_i,
  output logic [nsr_pkg::VALUE_W-1:0]   approx_root_o,
  output logic [nsr_pkg::STEP_W-1:0]    step_count_o,
  output logic                          limit_reached_o
);
  import nsr_pkg::*;

  localparam int unsigned NUM_W = VALUE_W + FRACTION_BITS;
  localparam int unsigned CNT_W = $clog2(MAX_STEPS + 1);

  logic [VALUE_W-1:0] value_q;
  logic [REF_W-1:0]   ref_q;
  logic [TOL_W-1:0]   tol_q;
  logic [VALUE_W-1:0] x_q, x_d;
  logic [CNT_W-1:0]   steps_q, steps_d;
  logic               limit_q, limit_d;

  logic [NUM_W-1:0]   dividend;
  logic [VALUE_W-1:0] divisor;
  logic [NUM_W-1:0]   quotient;
  logic               div_done;
  logic [NUM_W:0]     sum;
  logic [NUM_W-1:0]   half;
  logic [VALUE_W-1:0] step_x;
  logic [VALUE_W-1:0] seed_x;
  logic [VALUE_W-1:0] ref_ext;
  logic [VALUE_W-1:0] distance;

  // Divide the scaled value by the estimate, never by zero
  assign dividend = {value_q, {FRACTION_BITS{1'b0}}};
  assign divisor  = (x_q == '0) ? VALUE_W'(1) : x_q;

  nsr_div #(
    .DIVIDEND_W (NUM_W),
    .DIVISOR_W  (VALUE_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  // Average the estimate and the quotient, saturate to the word
  assign sum    = {{(NUM_W + 1 - VALUE_W){1'b0}}, divisor} + {1'b0, quotient};
  assign half   = sum[NUM_W:1];
  assign step_x = (|half[NUM_W-1:VALUE_W]) ? {VALUE_W{1'b1}} : half[VALUE_W-1:0];

  // Seed at half the value, raised to one LSB
  assign seed_x = (value_i[VALUE_W-1:1] == '0) ? VALUE_W'(1)
                                              : {1'b0, value_i[VALUE_W-1:1]};

  // Distance of the estimate from the reference root
  assign ref_ext  = {{(VALUE_W - REF_W){1'b0}}, ref_q};
  assign distance = (x_q >= ref_ext) ? (x_q - ref_ext) : (ref_ext - x_q);

  always_comb begin
    x_d     = x_q;
    steps_d = steps_q;
    limit_d = limit_q;
    if (cmd_i.load) begin
      x_d     = seed_x;
      steps_d = '0;
    end else if (cmd_i.update) begin
      x_d     = step_x;
      steps_d = steps_q + 1'b1;
    end
    if (cmd_i.finish) begin
      limit_d = !status_o.within_tol;
    end
  end

  // Hold the tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_tolerance_i;
    end
  end

  // Capture the transaction and advance the estimate
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      value_q <= value_i;
      ref_q   <= reference_root_i;
    end
    x_q     <= x_d;
    steps_q <= steps_d;
    limit_q <= limit_d;
  end

  assign status_o.div_done   = div_done;
  assign status_o.within_tol = (distance <= {{(VALUE_W - TOL_W){1'b0}}, tol_q});
  assign status_o.at_limit   = (steps_q == CNT_W'(MAX_STEPS));

  assign approx_root_o   = x_q;
  assign step_count_o    = STEP_W'(steps_q);
  assign limit_reached_o = limit_q;

endmodule

// File: design/nsr_ctrl.sv
module nsr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  output logic                  result_valid_o,
  output nsr_pkg::ctrl_cmd_t    cmd_o,
  input  nsr_pkg::ctrl_status_t status_i
);
  import nsr_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_GO   = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT = 3'd2;
  localparam logic [2:0] ST_CHECK    = 3'd3;
  localparam logic [2:0] ST_DONE     = 3'd4;

  logic [2:0] state_q, state_d;

  // Sequence load, divide, update and test for each transaction
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd_o.update = 1'b1;
          state_d      = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.within_tol || status_i.at_limit) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_DONE;
        end else begin
          state_d = ST_DIV_GO;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = (state_q == ST_DONE);

endmodule

// File: bench/newton_square_root_test.sv
`timescale 1ns / 1ps

module newton_square_root_test;

  import nsr_pkg::*;

  localparam int unsigned MAX_STEPS     = 32;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned TAIL_CYCLES   = 120;
  localparam logic [REF_W-1:0] REF_MAX  = '1;

  typedef struct packed {
    logic [VALUE_W-1:0] root;
    logic [STEP_W-1:0]  steps;
    logic               limit;
  } sqrt_result_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [REF_W-1:0]   ref_root;
    logic               typed;
    sqrt_result_t       want;
  } sqrt_row_t;

  // Directed rows; only the typed ones carry a hand-worked answer
  localparam int unsigned N_ROWS = 17;
  localparam sqrt_row_t DIRECTED [N_ROWS] = '{
    '{32'h0001_0000, 24'h01_0000, 1'b1, '{32'd65555, 6'd3, 1'b0}},   // 1.0, three steps
    '{32'h0004_0000, 24'h02_0000, 1'b1, '{32'h0002_0000, 6'd1, 1'b0}}, // start already exact
    '{32'h0000_0000, 24'h00_0000, 1'b1, '{32'd0, 6'd1, 1'b0}},       // value zero
    '{32'h0000_0001, 24'h00_0100, 1'b0, '0},  // zero start raised to one LSB
    '{32'h0000_0002, 24'h00_016A, 1'b0, '0},
    '{32'h0000_0003, 24'h00_0000, 1'b0, '0},
    '{32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, '0},  // both fields at maximum
    '{32'hFFFF_FFFF, 24'h00_0000, 1'b0, '0},  // step bound, large value
    '{32'h0000_0001, 24'hFF_FFFF, 1'b0, '0},  // step bound, tiny value
    '{32'h8000_0000, 24'hB5_04F3, 1'b0, '0},
    '{32'h7FFF_FFFF, 24'h00_0000, 1'b0, '0},
    '{32'h0002_0000, 24'h01_6A0A, 1'b0, '0},
    '{32'h5555_5555, 24'hAA_AAAA, 1'b0, '0},
    '{32'hAAAA_AAAA, 24'h55_5555, 1'b0, '0},
    '{32'h0000_0100, 24'h00_1000, 1'b0, '0},
    '{32'h0064_0000, 24'h0A_0000, 1'b0, '0},
    '{32'h0001_0000, 24'hFF_FFFF, 1'b0, '0}   // step bound at 1.0
  };

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [VALUE_W-1:0]  value_i;
  logic [REF_W-1:0]    reference_root_i;
  logic                result_valid_o;
  logic [VALUE_W-1:0]  approx_root_o;
  logic [STEP_W-1:0]   step_count_o;
  logic                limit_reached_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [TOL_W-1:0]    cfg_tolerance_i;

  logic [TOL_W-1:0]    tol_q;
  sqrt_result_t        root_exp_q[$];
  int unsigned         errors;
  int unsigned         n_items;
  int unsigned         n_results;
  int unsigned         n_settings;
  int unsigned         burst_left;
  int unsigned         stall_cnt;

  newton_square_root #(
    .MAX_STEPS    (MAX_STEPS),
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .value_i         (value_i),
    .reference_root_i(reference_root_i),
    .result_valid_o  (result_valid_o),
    .approx_root_o   (approx_root_o),
    .step_count_o    (step_count_o),
    .limit_reached_o (limit_reached_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_tolerance_i (cfg_tolerance_i)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Run the Babylonian iteration the way the block does it
  function automatic sqrt_result_t predict_root(input logic [VALUE_W-1:0] v,
                                                input logic [REF_W-1:0] r,
                                                input logic [TOL_W-1:0] tol);
    logic [63:0]  num;
    logic [63:0]  x;
    logic [63:0]  q;
    logic [63:0]  distance;
    logic [63:0]  r64;
    int unsigned  n;
    logic         met;
    sqrt_result_t res;
    num = {32'b0, v} << FRACTION_BITS;
    r64 = {40'b0, r};
    x   = {33'b0, v[VALUE_W-1:1]};
    if (x == 0) x = 64'd1;
    n   = 0;
    met = 1'b0;
    while (!met && n < MAX_STEPS) begin
      if (x == 0) x = 64'd1;
      q = num / x;
      x = (x + q) >> 1;
      if (x > 64'hFFFF_FFFF) x = 64'hFFFF_FFFF;
      n++;
      distance = (r64 > x) ? r64 - x : x - r64;
      if (distance <= {48'b0, tol}) met = 1'b1;
    end
    res.root  = x[VALUE_W-1:0];
    res.steps = n[STEP_W-1:0];
    res.limit = ~met;
    return res;
  endfunction

  // Integer square root, used to aim the reference near the true root
  function automatic logic [31:0] isqrt48(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = n;
    res  = 0;
    bitv = 64'h1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[31:0];
  endfunction

  // Mostly short gaps, a few long ones, and bursts with none
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  // Present one transaction and hold it until the block takes it
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic [REF_W-1:0] r,
                            input int unsigned gap, input logic typed,
                            input sqrt_result_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    value_i          <= v;
    reference_root_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    root_exp_q.push_back(typed ? want : predict_root(v, r, tol_q));
    n_items++;
  endtask

  // Drop start and wait for every outstanding result
  task automatic drain_results();
    start <= 1'b0;
    while (root_exp_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // Write the tolerance while the block is idle
  task automatic set_tolerance(input logic [TOL_W-1:0] t);
    drain_results();
    repeat ($urandom_range(0, 6)) @(posedge clk_i);
    cfg_valid_i     <= 1'b1;
    cfg_tolerance_i <= t;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    tol_q = t;
    n_settings++;
    cfg_valid_i     <= 1'b0;
    cfg_tolerance_i <= TOL_W'($urandom_range(0, 16'hFFFF));
  endtask

  // Mostly references near the true root, some far off to hit the step bound
  task automatic run_random(input int unsigned count);
    logic [VALUE_W-1:0] v;
    logic [REF_W-1:0]   r;
    logic [31:0]        root;
    longint             span;
    longint             aim;
    for (int unsigned k = 0; k < count; k++) begin
      v = $urandom >> $urandom_range(0, 31);
      if (v == 0) v = 1;
      if ($urandom_range(0, 99) < 88) begin
        root = isqrt48({32'b0, v} << FRACTION_BITS);
        span = (tol_q == 0) ? 1 : longint'(tol_q) / 2 + 1;
        aim  = longint'(root) + longint'($urandom_range(0, 2 * span)) - span;
        if (aim < 0) aim = 0;
        if (aim > longint'(REF_MAX)) aim = longint'(REF_MAX);
        r = aim[REF_W-1:0];
      end else begin
        r = REF_W'($urandom_range(0, REF_MAX));
      end
      send_value(v, r, pick_gap(), 1'b0, '0);
    end
  endtask

  // Compare each result strobe with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (root_exp_q.size() == 0) begin
        $display("%0t: unexpected result root=%h steps=%0d limit=%b", $time,
                 approx_root_o, step_count_o, limit_reached_o);
        errors++;
      end else begin
        sqrt_result_t want;
        want = root_exp_q.pop_front();
        n_results++;
        if (approx_root_o !== want.root) begin
          $display("%0t: approx_root expected %h actual %h", $time, want.root, approx_root_o);
          errors++;
        end
        if (step_count_o !== want.steps) begin
          $display("%0t: step_count expected %0d actual %0d", $time, want.steps,
                   step_count_o);
          errors++;
        end
        if (limit_reached_o !== want.limit) begin
          $display("%0t: limit_reached expected %b actual %b", $time, want.limit,
                   limit_reached_o);
          errors++;
        end
      end
    end
  end

  // Count cycles without any transaction and stop a hung run
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    start            = 1'b0;
    value_i          = '0;
    reference_root_i = '0;
    cfg_valid_i      = 1'b0;
    cfg_tolerance_i  = '0;
    errors           = 0;
    n_items          = 0;
    n_results        = 0;
    n_settings       = 1;
    burst_left       = 0;
    stall_cnt        = 0;
    tol_q            = TOL_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows at the reset tolerance
    for (int unsigned i = 0; i < N_ROWS; i++) begin
      send_value(DIRECTED[i].value, DIRECTED[i].ref_root, (i % 3 == 0) ? 0 : pick_gap(),
                 DIRECTED[i].typed, DIRECTED[i].want);
    end
    run_random(40);

    // Sweep the tolerance through its extremes and some random settings
    set_tolerance('0);
    run_random(60);
    set_tolerance('1);
    run_random(200);
    set_tolerance(TOL_W'($urandom_range(0, 16'hFFFF)));
    run_random(250);
    set_tolerance(TOL_W'($urandom_range(1, 1000)));
    run_random(250);
    set_tolerance(TOL_RESET);
    run_random(300);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (root_exp_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, root_exp_q.size());
      errors++;
    end

    $display("Sent %0d square-root transactions over %0d tolerance settings.", n_items,
             n_settings);
    $display("Checked %0d results, %0d mismatches.", n_results, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
design/nsr_pkg.sv
design/nsr_div.sv
design/nsr_datapath.sv
design/nsr_ctrl.sv
design/newton_square_root.sv
bench/newton_square_root_test.sv
